// File: rtl/pidal_pkg.sv
// Shared types and constants for the process-slot allocator.
// Used by pidal_ctrl, pidal_dp and pid_allocator_with_root_lookup; no dependencies.

package pidal_pkg;

	// Number of allocatable slots (slot 0 is the root and is always taken).
	localparam int unsigned MAX_PROCS = 8;

	// Field widths fixed by the interface.
	localparam int unsigned OP_W   = 2;
	localparam int unsigned SLOT_W = 4;

	// Live count and walk step counter both reach MAX_PROCS.
	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_ROOT  = 2'd2
	} opcode_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture input transaction
		logic exec_op;   // run allocate / free / unused opcode, write result
		logic walk_step; // follow one parent link
		logic walk_ok;   // write success result with current slot
		logic fail;      // write failure result
	} pidal_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic op_is_root;
		logic start_bad;  // walk start slot beyond MAX_PROCS
		logic nxt_zero;   // current slot's parent is 0
		logic walk_stop;  // cap reached or link out of range
		logic out_free;   // result register can take a new result
	} pidal_sts_t;

endpackage

// File: rtl/pidal_ctrl.sv
// Sequencing state machine for the process-slot allocator.
// Depends on pidal_pkg; drives pidal_dp through pidal_cmd_t.

module pidal_ctrl
	import pidal_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  pidal_sts_t sts,
	output pidal_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_OP   = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_OP;
				end
			end
			ST_OP: begin
				if (!sts.op_is_root) begin
					if (sts.out_free) begin
						cmd.exec_op = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (sts.start_bad) begin
					if (sts.out_free) begin
						cmd.fail = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.nxt_zero) begin
					if (sts.out_free) begin
						cmd.walk_ok = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (sts.walk_stop) begin
					if (sts.out_free) begin
						cmd.fail = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: rtl/pidal_dp.sv
// Datapath: present bits, parent table, live count, walk registers, result register.
// Depends on pidal_pkg; commanded by pidal_ctrl.

module pidal_dp
	import pidal_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OP_W-1:0]   opcode,
	input  logic [SLOT_W-1:0] slot,
	input  logic [SLOT_W-1:0] parent_slot,
	input  pidal_cmd_t        cmd,
	output pidal_sts_t        sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] result_slot
);

	// Slot 0 held present so the table indexes uniformly.
	logic [MAX_PROCS:0]  present_q;
	logic [SLOT_W-1:0]   parent_q [MAX_PROCS+1];
	logic [CNT_W-1:0]    count_q;

	logic [OP_W-1:0]     op_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W-1:0]   par_q;
	logic [CNT_W-1:0]    steps_q;

	logic                out_valid_q;
	logic                status_q;
	logic [SLOT_W-1:0]   result_q;

	logic                cur_in_range;
	logic [SLOT_W-1:0]   nxt;
	logic                cur_present;
	logic                any_free;
	logic [SLOT_W-1:0]   alloc_idx;
	logic                alloc_ok;
	logic                free_ok;
	logic                out_free;
	logic                res_wr;
	logic                res_status;
	logic [SLOT_W-1:0]   res_slot;

	assign cur_in_range = (32'(cur_q) <= MAX_PROCS);
	assign nxt          = cur_in_range ? parent_q[cur_q] : '0;
	assign cur_present  = cur_in_range ? present_q[cur_q] : 1'b0;

	// Lowest free slot, 1..MAX_PROCS.
	always_comb begin
		any_free  = 1'b0;
		alloc_idx = '0;
		for (int i = MAX_PROCS; i >= 1; i--) begin
			if (!present_q[i]) begin
				any_free  = 1'b1;
				alloc_idx = SLOT_W'(i);
			end
		end
	end

	assign alloc_ok = any_free && (32'(count_q) <= MAX_PROCS);
	assign free_ok  = (cur_q != '0) && cur_in_range && (count_q != '0) && cur_present;

	assign out_free = !out_valid_q || !out_stall;
	assign res_wr   = cmd.exec_op || cmd.walk_ok || cmd.fail;

	assign sts.op_is_root = (op_q == OP_ROOT);
	assign sts.start_bad  = !cur_in_range;
	assign sts.nxt_zero   = (nxt == '0);
	assign sts.walk_stop  = (32'(steps_q) >= MAX_PROCS) || (32'(nxt) > MAX_PROCS);
	assign sts.out_free   = out_free;

	// Allocator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= (MAX_PROCS+1)'(1);
			count_q   <= '0;
			for (int i = 0; i <= MAX_PROCS; i++) begin
				parent_q[i] <= '0;
			end
		end else if (cmd.exec_op) begin
			case (op_q)
				OP_ALLOC: begin
					if (alloc_ok) begin
						present_q[alloc_idx] <= 1'b1;
						parent_q[alloc_idx]  <= par_q;
						count_q              <= count_q + CNT_W'(1);
					end
				end
				OP_FREE: begin
					if (free_ok) begin
						present_q[cur_q] <= 1'b0;
						count_q          <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Captured transaction and walk position.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			cur_q   <= slot;
			par_q   <= parent_slot;
			steps_q <= '0;
		end else if (cmd.walk_step) begin
			cur_q   <= nxt;
			steps_q <= steps_q + CNT_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_wr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Failure with slot 0 unless an operation succeeds.
	always_comb begin
		res_status = 1'b1;
		res_slot   = '0;
		if (cmd.walk_ok) begin
			res_status = 1'b0;
			res_slot   = cur_q;
		end else if (cmd.exec_op) begin
			case (op_q)
				OP_ALLOC: begin
					if (alloc_ok) begin
						res_status = 1'b0;
						res_slot   = alloc_idx;
					end
				end
				OP_FREE: begin
					if (free_ok) begin
						res_status = 1'b0;
						res_slot   = nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			status_q <= res_status;
			result_q <= res_slot;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_slot = result_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_PROCS)
		else $error("live count above slot total");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(present_q[MAX_PROCS:1]))
		else $error("live count disagrees with present bits");

	a_root_present: assert property (@(posedge clk) disable iff (!arst_n)
		present_q[0] && parent_q[0] == '0)
		else $error("root slot disturbed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> result_q == '0)
		else $error("failed result carries a nonzero slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !res_wr)
		else $error("pending result overwritten");
`endif

endmodule

// File: rtl/pid_allocator_with_root_lookup.sv
// Top level of the process-slot allocator with root lookup.
// Depends on pidal_pkg, pidal_ctrl and pidal_dp.
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  --------------------------------
// in       input      in_valid / in_stall  opcode[1:0] slot[3:0] parent_slot[3:0]
// out      output     out_valid/out_stall  status result_slot[3:0]
//
// Sequence: one input transaction at a time. Allocate, free and unused opcodes
//   are captured, then executed with their result written from the dispatch
//   state; find-root moves on to the walk state, which follows parent links one
//   at a time through the single parent-table read, at most MAX_PROCS of them.
// Reset: arst_n asynchronous, active low; slots 1..8 free, parents and count zero.
//   No clearing pass: the tables are flops and clear at once.
// Stalls: the result register parts the two sides; a new transaction is taken
//   while a result still waits, and the next result waits for the register.

module pid_allocator_with_root_lookup
	import pidal_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [SLOT_W-1:0] slot,
	input  logic [SLOT_W-1:0] parent_slot,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] result_slot
);

	pidal_cmd_t cmd;
	pidal_sts_t sts;

	// Sequencer: idle / dispatch / parent walk.
	pidal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot tables, walk registers and result register.
	pidal_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.slot        (slot),
		.parent_slot (parent_slot),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.result_slot (result_slot)
	);

endmodule

// File: verif/tb_pid_allocator_with_root_lookup.sv
// Testbench for pid_allocator_with_root_lookup: a table of directed transactions, then random
// traffic, scored by a slot-table predictor or typed expectation. Needs pidal_pkg and allocator RTL.
`timescale 1ns / 1ps

module tb_pid_allocator_with_root_lookup;
	import pidal_pkg::*;

	localparam int unsigned CLK_HALF       = 5;
	localparam int unsigned N_RANDOM       = 425;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// longest find-root follows MAX_PROCS links; leave a margin after the last result
	localparam int unsigned DRAIN_CYCLES   = 4 * (MAX_PROCS + 3);

	// opcode left unassigned by the package; the block must reject it
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic            ST_OK     = 1'b0;
	localparam logic            ST_FAIL   = 1'b1;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot;
	} slot_result_t;

	// one directed transaction; 'typed' rows carry a hand-written expectation
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] parent;
		logic              typed;
		logic              status;
		logic [SLOT_W-1:0] res;
	} directed_row_t;

	localparam int unsigned N_DIRECTED = 25;
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{OP_ROOT,   4'd0,  4'd0,  1'b1, ST_OK,   4'd0},  // root of slot 0 straight after reset
		'{OP_FREE,   4'd0,  4'd0,  1'b1, ST_FAIL, 4'd0},  // slot 0 can never be freed
		'{OP_FREE,   4'd1,  4'd0,  1'b1, ST_FAIL, 4'd0},  // nothing live yet
		'{OP_ROOT,   4'd9,  4'd0,  1'b1, ST_FAIL, 4'd0},  // start beyond MAX_PROCS
		'{OP_UNUSED, 4'd15, 4'd15, 1'b1, ST_FAIL, 4'd0},  // unused opcode
		'{OP_ALLOC,  4'd0,  4'd0,  1'b1, ST_OK,   4'd1},  // first allocation lands on slot 1
		'{OP_ALLOC,  4'd7,  4'd1,  1'b0, ST_OK,   4'd0},
		'{OP_ALLOC,  4'd0,  4'd2,  1'b0, ST_OK,   4'd0},
		'{OP_ROOT,   4'd3,  4'd0,  1'b0, ST_OK,   4'd0},  // 3 -> 2 -> 1
		'{OP_ALLOC,  4'd0,  4'd15, 1'b0, ST_OK,   4'd0},  // parent stored out of range
		'{OP_ROOT,   4'd4,  4'd0,  1'b1, ST_FAIL, 4'd0},  // link out of range
		'{OP_ALLOC,  4'd0,  4'd6,  1'b0, ST_OK,   4'd0},
		'{OP_ALLOC,  4'd0,  4'd5,  1'b0, ST_OK,   4'd0},  // 5 <-> 6 loop
		'{OP_ROOT,   4'd5,  4'd0,  1'b1, ST_FAIL, 4'd0},  // walk cap
		'{OP_ALLOC,  4'd0,  4'd8,  1'b0, ST_OK,   4'd0},
		'{OP_ALLOC,  4'd0,  4'd7,  1'b0, ST_OK,   4'd0},  // table now full
		'{OP_ALLOC,  4'd0,  4'd0,  1'b1, ST_FAIL, 4'd0},  // allocate when full
		'{OP_FREE,   4'd8,  4'd0,  1'b0, ST_OK,   4'd0},
		'{OP_FREE,   4'd8,  4'd0,  1'b1, ST_FAIL, 4'd0},  // double free
		'{OP_ROOT,   4'd8,  4'd0,  1'b1, ST_FAIL, 4'd0},  // free slot, stale link loops 8 <-> 7
		'{OP_FREE,   4'd2,  4'd0,  1'b0, ST_OK,   4'd0},
		'{OP_ALLOC,  4'd0,  4'd3,  1'b0, ST_OK,   4'd0},  // lowest free slot reused
		'{OP_FREE,   4'd15, 4'd0,  1'b1, ST_FAIL, 4'd0},  // free beyond MAX_PROCS
		'{OP_ROOT,   4'd1,  4'd0,  1'b0, ST_OK,   4'd0},
		'{OP_ALLOC,  4'd0,  4'd9,  1'b0, ST_OK,   4'd0}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   opcode      = '0;
	logic [SLOT_W-1:0] slot        = '0;
	logic [SLOT_W-1:0] parent_slot = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              status;
	logic [SLOT_W-1:0] result_slot;

	// predictor state: slot 0 is the root and reads as present throughout
	logic              present_tbl [0:MAX_PROCS];
	logic [SLOT_W-1:0] parent_tbl  [0:MAX_PROCS];
	int unsigned       live_procs;

	slot_result_t pending_results [$];
	int unsigned  fail_count  = 0;
	int unsigned  burst_left  = 0;
	int unsigned  stall_left  = 0;
	int unsigned  idle_cycles = 0;

	pid_allocator_with_root_lookup i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.slot       (slot),
		.parent_slot(parent_slot),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.result_slot(result_slot)
	);

	always #CLK_HALF clk = ~clk;

	// Applies one transaction to the slot tables and returns the result it should give.
	function automatic slot_result_t predict_slot_op(input logic [OP_W-1:0] op,
		input logic [SLOT_W-1:0] s, input logic [SLOT_W-1:0] p);
		slot_result_t      res;
		logic [SLOT_W-1:0] cur;
		logic [SLOT_W-1:0] nxt;
		logic              done;
		res  = '{status: ST_FAIL, slot: '0};
		done = 1'b0;
		case (op)
		OP_ALLOC: begin
			if (live_procs <= MAX_PROCS) begin
				for (int i = 1; i <= MAX_PROCS && !done; i++) begin
					if (!present_tbl[i]) begin
						present_tbl[i] = 1'b1;
						parent_tbl[i]  = p;
						live_procs++;
						res  = '{status: ST_OK, slot: SLOT_W'(i)};
						done = 1'b1;
					end
				end
			end
		end
		OP_FREE: begin
			if (s != 0 && s <= MAX_PROCS && live_procs != 0 && present_tbl[s]) begin
				present_tbl[s] = 1'b0;
				live_procs--;
				res = '{status: ST_OK, slot: parent_tbl[s]};
			end
		end
		OP_ROOT: begin
			// present bits are not consulted; stale links are followed as they stand
			if (s <= MAX_PROCS) begin
				cur = s;
				for (int step = 0; step <= MAX_PROCS && !done; step++) begin
					nxt = parent_tbl[cur];
					if (nxt == 0) begin
						res  = '{status: ST_OK, slot: cur};
						done = 1'b1;
					end else if (step >= MAX_PROCS || nxt > MAX_PROCS) begin
						done = 1'b1;
					end else begin
						cur = nxt;
					end
				end
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// random live slot, or 0 when only the root is present
	function automatic logic [SLOT_W-1:0] pick_live_slot();
		logic [SLOT_W-1:0] cands [$];
		for (int i = 1; i <= MAX_PROCS; i++)
			if (present_tbl[i]) cands.push_back(SLOT_W'(i));
		if (cands.size() == 0)
			return '0;
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	// Sender: transactions go out in bursts; between bursts in_valid drops for a random gap.
	// Returns at the edge where the transaction was taken.
	task automatic send_transaction(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s,
		input logic [SLOT_W-1:0] p);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 8);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		slot        <= s;
		parent_slot <= p;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// Random transaction: mostly well-formed (live slots, live parents), some noise.
	task automatic send_random();
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] p;
		int unsigned       pick;
		int unsigned       r;
		pick = $urandom_range(0, 99);
		r    = $urandom_range(0, 99);
		s    = SLOT_W'($urandom_range(0, 15));
		p    = SLOT_W'($urandom_range(0, 15));
		if (pick < 32) begin
			op = OP_ALLOC;
			if (r < 70)
				p = pick_live_slot();
			else if (r < 85)
				p = '0;
		end else if (pick < 62) begin
			op = OP_FREE;
			if (r < 80)
				s = pick_live_slot();
		end else if (pick < 92) begin
			op = OP_ROOT;
			if (r < 70)
				s = pick_live_slot();
			else if (r < 90)
				s = SLOT_W'($urandom_range(0, MAX_PROCS));
		end else if (pick < 97) begin
			op = OP_W'($urandom_range(0, 3));
		end else begin
			op = OP_UNUSED;
		end
		send_transaction(op, s, p);
		pending_results.push_back(predict_slot_op(op, s, p));
	endtask

	// Result side: score every accepted result, then move the stall pattern on.
	always @(posedge clk) begin
		slot_result_t exp_res;
		logic         hold;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d result_slot %0d", status, result_slot);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, status);
					fail_count++;
				end
				if (result_slot !== exp_res.slot) begin
					$error("result_slot: expected %0d, actual %0d", exp_res.slot, result_slot);
					fail_count++;
				end
			end
		end
		// short stall runs mixed with longer free-flowing stretches
		if (stall_left == 0) begin
			hold       = ($urandom_range(0, 2) == 0);
			stall_left = hold ? $urandom_range(1, 5) : $urandom_range(1, 30);
			out_stall <= hold;
		end else begin
			stall_left--;
		end
	end

	// Watchdog: too many cycles without any transaction on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		slot_result_t predicted;
		for (int i = 0; i <= MAX_PROCS; i++) begin
			present_tbl[i] = (i == 0);
			parent_tbl[i]  = '0;
		end
		live_procs = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: the predictor tracks every row, typed rows use their own expectation
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_transaction(DIRECTED[i].op, DIRECTED[i].slot, DIRECTED[i].parent);
			predicted = predict_slot_op(DIRECTED[i].op, DIRECTED[i].slot, DIRECTED[i].parent);
			if (DIRECTED[i].typed)
				pending_results.push_back('{status: DIRECTED[i].status, slot: DIRECTED[i].res});
			else
				pending_results.push_back(predicted);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			// halfway through, hold the input side until the block has fully drained
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				burst_left = 0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			send_random();
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
